// ----- rtl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by u8u16_result_queue and utf8_to_utf16_decoder.
package u8u16_pkg;

   localparam int UNIT_COUNT_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH             = 8;
   localparam int MAX_RESULTS             = 3;

   // Configuration register indexes
   localparam logic CSR_STRICT_MODE     = 1'b0;
   localparam logic CSR_TARGET_CAPACITY = 1'b1;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;
   localparam logic [15:0] REPLACEMENT    = 16'hFFFD;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_SRC_EXHAUSTED = 2'd1,
      ST_SRC_ILLEGAL   = 2'd2,
      ST_TGT_EXHAUSTED = 2'd3
   } status_type;

   typedef struct packed {
      logic        is_status;
      logic [15:0] code_unit;
      status_type  status;
      logic        last_of_run;
   } result_type;

endpackage

// ----- rtl/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 stream decoder, top level.
// Depends on u8u16_pkg and u8u16_result_queue.
//
// Takes one UTF-8 byte per transfer on req_ (tlast marks the final byte of a
// string) and gives UTF-16 code units and one status per string on rsp_. A byte
// can be taken every cycle: the sequence state is updated by one shallow pass of
// logic at the input transfer, and the zero to three results it causes go into
// an eight-entry result queue that drains one transfer per cycle while the
// output is not stalled; results are registered in it before they are offered.
// req_tready drops only while that queue holds more than five results, so bytes
// go in every cycle as long as they cause no more than one result each on
// average and rsp_tready stays high; beyond that the output sets the pace.
// Legality is checked when the last byte of a sequence arrives (overlongs,
// surrogate/range limits on the second byte, leads above F4, 5- and 6-byte
// leads). strict_mode=1 rejects decoded surrogates and values above 10FFFF;
// strict_mode=0 replaces them with U+FFFD. After the first error of a string
// the block discards bytes until tlast. Write configuration only while idle.
module utf8_to_utf16_decoder
   import u8u16_pkg::*;
#(
   parameter int UNIT_COUNT_BITS = UNIT_COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_string
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] code_unit, [17:16] status, [23:18] zero
   output logic        rsp_tuser,   // [0] is_status
   output logic        rsp_tlast,   // last_of_run
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Capacity compare width: wide enough for both the counter and the register
   localparam int CW = (UNIT_COUNT_BITS > 16) ? UNIT_COUNT_BITS : 16;
   localparam logic [CW:0] COUNT_MAX = (CW+1)'((64'd1 << UNIT_COUNT_BITS) - 64'd1);

   // configuration registers
   logic        strict_ff;
   logic [15:0] capacity_ff;

   // sequence state
   logic [7:0]                 lead_ff,   lead_in;
   logic [7:0]                 second_ff, second_in;
   logic [2:0]                 needed_ff, needed_in;
   logic [2:0]                 seen_ff,   seen_in;
   logic [20:0]                acc_ff,    acc_in;    // at most 21 bits matter
   logic                       trail_bad_ff, trail_bad_in;
   logic [UNIT_COUNT_BITS-1:0] units_ff,  units_in;
   logic                       halted_ff, halted_in;

   // step values
   logic                       accept;
   logic [7:0]                 in_byte;
   logic                       eos;
   logic [7:0]                 lead_s, second_s;
   logic [2:0]                 needed_s, seen_s;
   logic [20:0]                acc_s;
   logic                       trail_s;
   logic                       complete;
   logic                       legal;
   logic [CW:0]                cap, units_w;
   logic [19:0]                pair_off;
   logic [15:0]                unit0, unit1;
   logic [1:0]                 n_units;
   status_type                 seq_status;
   status_type                 out_status;
   logic                       failed;
   logic                       emit_status;
   logic [1:0]                 push_count;
   result_type                 push_entry [MAX_RESULTS];
   result_type                 head;
   logic                       has_room;

   assign in_byte    = req_tdata;
   assign eos        = req_tlast;
   assign req_tready = has_room;
   assign accept     = req_tvalid && has_room;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff   <= 1'b1;
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STRICT_MODE:     strict_ff   <= csr_wdata[0];
            CSR_TARGET_CAPACITY: capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective capacity: smaller of the register and the counter maximum
   always_comb begin
      cap     = ((CW+1)'(capacity_ff) < COUNT_MAX) ? (CW+1)'(capacity_ff) : COUNT_MAX;
      units_w = (CW+1)'(units_ff);
   end

   // sequence gathering for this byte
   always_comb begin
      lead_s   = lead_ff;
      second_s = second_ff;
      needed_s = needed_ff;
      seen_s   = seen_ff;
      acc_s    = acc_ff;
      trail_s  = trail_bad_ff;
      if (needed_ff == 3'd0) begin
         lead_s   = in_byte;
         second_s = 8'h00;
         trail_s  = 1'b0;
         seen_s   = 3'd1;
         if (in_byte < 8'hC0) begin
            needed_s = 3'd1;
            acc_s    = 21'(in_byte[6:0]);
         end else if (in_byte < 8'hE0) begin
            needed_s = 3'd2;
            acc_s    = 21'(in_byte[4:0]);
         end else if (in_byte < 8'hF0) begin
            needed_s = 3'd3;
            acc_s    = 21'(in_byte[3:0]);
         end else begin
            needed_s = (in_byte < 8'hF8) ? 3'd4 : ((in_byte < 8'hFC) ? 3'd5 : 3'd6);
            acc_s    = 21'(in_byte[2:0]);
         end
      end else begin
         seen_s = seen_ff + 3'd1;
         if (seen_s == 3'd2) begin
            second_s = in_byte;
         end else if (in_byte < 8'h80 || in_byte > 8'hBF) begin
            trail_s = 1'b1;
         end
         acc_s = {acc_ff[14:0], in_byte[5:0]};
      end
      complete = (seen_s >= needed_s);
   end

   // legality of a finished sequence
   always_comb begin
      legal = 1'b1;
      if (needed_s > 3'd4) legal = 1'b0;
      if (needed_s >= 3'd2) begin
         if (second_s > 8'hBF) legal = 1'b0;
         case (lead_s)
            8'hE0:   if (second_s < 8'hA0) legal = 1'b0;
            8'hED:   if (second_s > 8'h9F) legal = 1'b0;
            8'hF0:   if (second_s < 8'h90) legal = 1'b0;
            8'hF4:   if (second_s > 8'h8F) legal = 1'b0;
            default: if (second_s < 8'h80) legal = 1'b0;
         endcase
      end
      if (needed_s >= 3'd3 && trail_s) legal = 1'b0;
      if (lead_s >= 8'h80 && lead_s < 8'hC2) legal = 1'b0;
      if (lead_s > 8'hF4) legal = 1'b0;
   end

   // decode to code units; checks in order capacity, surrogate, range, pair room
   always_comb begin
      pair_off   = 20'(acc_s - 21'h010000);
      unit0      = acc_s[15:0];
      unit1      = 16'hDC00 + 16'(pair_off[9:0]);
      n_units    = 2'd0;
      seq_status = ST_OK;
      if (!legal) begin
         seq_status = ST_SRC_ILLEGAL;
      end else if (units_w >= cap) begin
         seq_status = ST_TGT_EXHAUSTED;
      end else if (acc_s <= 21'h00FFFF) begin
         if (acc_s >= 21'h00D800 && acc_s <= 21'h00DFFF) begin
            if (strict_ff) begin
               seq_status = ST_SRC_ILLEGAL;
            end else begin
               unit0   = REPLACEMENT;
               n_units = 2'd1;
            end
         end else begin
            n_units = 2'd1;
         end
      end else if (acc_s > 21'h10FFFF) begin
         if (strict_ff) begin
            seq_status = ST_SRC_ILLEGAL;
         end else begin
            unit0   = REPLACEMENT;
            n_units = 2'd1;
         end
      end else if (units_w + (CW+1)'(1) >= cap) begin
         seq_status = ST_TGT_EXHAUSTED;
      end else begin
         unit0   = 16'hD800 + 16'(pair_off[19:10]);
         n_units = 2'd2;
      end
      if (!complete) n_units = 2'd0;
   end

   // status result and the list of results for this byte
   always_comb begin
      failed     = 1'b0;
      out_status = ST_OK;
      if (complete) begin
         if (seq_status != ST_OK) begin
            failed     = 1'b1;
            out_status = seq_status;
         end
      end else if (eos) begin
         failed     = 1'b1;
         out_status = ST_SRC_EXHAUSTED;
      end
      emit_status = failed || eos;

      push_count = 2'd0;
      if (accept && !halted_ff) begin
         push_count = n_units + 2'(emit_status);
      end

      for (int k = 0; k < MAX_RESULTS; k++) begin
         push_entry[k].is_status = 1'b1;
         push_entry[k].code_unit = 16'h0000;
         push_entry[k].status    = out_status;
         push_entry[k].last_of_run = (k == int'(push_count) - 1);
      end
      if (n_units >= 2'd1) begin
         push_entry[0].is_status = 1'b0;
         push_entry[0].code_unit = unit0;
         push_entry[0].status    = ST_OK;
      end
      if (n_units == 2'd2) begin
         push_entry[1].is_status = 1'b0;
         push_entry[1].code_unit = unit1;
         push_entry[1].status    = ST_OK;
      end
   end

   // next state
   always_comb begin
      lead_in      = lead_ff;
      second_in    = second_ff;
      needed_in    = needed_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      trail_bad_in = trail_bad_ff;
      units_in     = units_ff;
      halted_in    = halted_ff;
      if (accept) begin
         if (halted_ff) begin
            if (eos) begin
               halted_in = 1'b0;
               needed_in = 3'd0;
               units_in  = '0;
            end
         end else begin
            lead_in      = lead_s;
            second_in    = second_s;
            needed_in    = needed_s;
            seen_in      = seen_s;
            acc_in       = acc_s;
            trail_bad_in = trail_s;
            units_in     = units_ff + UNIT_COUNT_BITS'(n_units);
            if (complete || eos) begin
               needed_in = 3'd0;
            end
            if (eos) begin
               units_in  = '0;
               halted_in = 1'b0;
            end else if (failed) begin
               halted_in = 1'b1;
            end
         end
      end
   end

   // Only needed_ff steers control; the other sequence fields are reloaded
   // whenever a new sequence opens, so clearing needed_ff clears the sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff <= 3'd0;
         units_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         needed_ff <= needed_in;
         units_ff  <= units_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff      <= lead_in;
      second_ff    <= second_in;
      seen_ff      <= seen_in;
      acc_ff       <= acc_in;
      trail_bad_ff <= trail_bad_in;
   end

   u8u16_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_entry (push_entry),
      .pop        (rsp_tready),
      .has_room   (has_room),
      .not_empty  (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = {6'b000000, head.status, head.code_unit};
   assign rsp_tuser = head.is_status;
   assign rsp_tlast = head.last_of_run;

endmodule

// ----- rtl/u8u16_result_queue.sv -----
// Small result queue: takes up to three results per cycle, gives one per transfer.
// Depends on u8u16_pkg.
module u8u16_result_queue
   import u8u16_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  result_type push_entry [MAX_RESULTS],
   input  logic       pop,
   output logic       has_room,
   output logic       not_empty,
   output result_type head
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   result_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;
   logic                  do_pop;

   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= (PTR_BITS+1)'(QUEUE_DEPTH - MAX_RESULTS));
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(do_pop);
      count_in  = count_ff + (PTR_BITS+1)'(push_count) - (PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (k < int'(push_count)) begin
            mem_ff[wr_ptr_ff + PTR_BITS'(k)] <= push_entry[k];
         end
      end
   end

endmodule
